// ----- src/ffba_pkg.sv -----
// Package for the first-fit block allocator: heap geometry constants,
// status codes, request codes and the controller/datapath command and status structs.
package ffba_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 17;
	localparam int MIN_CAPACITY = 24;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CAP_W = 17;
	localparam int OFS_W = 16;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_FREE = 2'd2;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_INIT  = 3'd1,  // write the whole-heap free block at index
		OP_READ  = 3'd2,  // read entry at index into the current-entry registers
		OP_NEXT  = 3'd3,  // read entry at index into the next-entry registers
		OP_MOVE  = 3'd4,  // one step of a table move: read src, write the last read at index
		OP_WRCUR = 3'd5,  // write the current-entry registers back at index
		OP_WRREM = 3'd6   // write the split remainder at index, current keeps capacity q
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] src;      // move: source index
		logic            mv_wr;    // move: write the previously read entry
		logic            absorb;   // add header and next capacity to current
		logic            set_free;
		logic            clr_free;
		logic            cnt_inc;
		logic            cnt_dec;
		logic            load_req;
		logic [CAP_W-1:0] req_bytes;
		logic [OFS_W-1:0] roff;
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic            cur_free;
		logic            nxt_free;
		logic            fits;      // current capacity >= request
		logic            can_split;
		logic            match;     // current start + header == release offset
		logic [OFS_W-1:0] payload;
	} dp_stat_t;

endpackage

// ----- src/ffba_datapath.sv -----
// Datapath: the block table memories, entry count and current/next entry registers.
// Depends on ffba_pkg.
module ffba_datapath import ffba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat
);

	logic [OFS_W-1:0] start_mem [MAX_BLOCKS];
	logic [CAP_W-1:0] cap_mem   [MAX_BLOCKS];
	logic             free_mem  [MAX_BLOCKS];

	logic [CNT_W-1:0] count_q;
	logic [OFS_W-1:0] cur_start_q, nxt_start_q;
	logic [CAP_W-1:0] cur_cap_q, nxt_cap_q, req_q;
	logic             cur_free_q, nxt_free_q;
	logic [OFS_W-1:0] roff_q;
	logic [OFS_W-1:0] sh_start_q;
	logic [CAP_W-1:0] sh_cap_q;
	logic             sh_free_q;
	logic [CAP_W-1:0] q_w;
	logic [CAP_W+1:0] split_need;

	assign q_w = (req_q < CAP_W'(MIN_CAPACITY)) ? CAP_W'(MIN_CAPACITY) : req_q;
	assign split_need = {2'b0, q_w} + (CAP_W+2)'(HEADER_BYTES + MIN_CAPACITY);

	// Table writes. Entry 0 is written by the controller's init pass; the rest
	// start undefined and are only read once they have been written.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT: begin
				start_mem[cmd.idx] <= '0;
				cap_mem[cmd.idx]   <= CAP_W'(HEAP_BYTES - HEADER_BYTES);
				free_mem[cmd.idx]  <= 1'b1;
			end
			OP_MOVE: begin
				if (cmd.mv_wr) begin
					start_mem[cmd.idx] <= sh_start_q;
					cap_mem[cmd.idx]   <= sh_cap_q;
					free_mem[cmd.idx]  <= sh_free_q;
				end
			end
			OP_WRREM: begin
				start_mem[cmd.idx] <= cur_start_q + OFS_W'(HEADER_BYTES) + q_w[OFS_W-1:0];
				cap_mem[cmd.idx]   <= cur_cap_q - q_w - CAP_W'(HEADER_BYTES);
				free_mem[cmd.idx]  <= 1'b1;
			end
			OP_WRCUR: begin
				start_mem[cmd.idx] <= cur_start_q;
				cap_mem[cmd.idx]   <= cur_cap_q;
				free_mem[cmd.idx]  <= cur_free_q;
			end
			default: ;
		endcase
	end

	// Current entry: loaded by a read, then grown by merges, trimmed by a split
	// and marked free or taken.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_READ) begin
			cur_start_q <= start_mem[cmd.idx];
			cur_cap_q   <= cap_mem[cmd.idx];
			cur_free_q  <= free_mem[cmd.idx];
		end else begin
			if (cmd.absorb)
				cur_cap_q <= cur_cap_q + CAP_W'(HEADER_BYTES) + nxt_cap_q;
			else if (cmd.op == OP_WRREM)
				cur_cap_q <= q_w;
			if (cmd.set_free)
				cur_free_q <= 1'b1;
			else if (cmd.clr_free)
				cur_free_q <= 1'b0;
		end
	end

	// Next entry, move buffer and the request operands.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_NEXT) begin
			nxt_start_q <= start_mem[cmd.idx];
			nxt_cap_q   <= cap_mem[cmd.idx];
			nxt_free_q  <= free_mem[cmd.idx];
		end
		if (cmd.op == OP_MOVE) begin
			sh_start_q <= start_mem[cmd.src];
			sh_cap_q   <= cap_mem[cmd.src];
			sh_free_q  <= free_mem[cmd.src];
		end
		if (cmd.load_req) begin
			req_q  <= cmd.req_bytes;
			roff_q <= cmd.roff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else begin
			if (cmd.cnt_inc)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.cnt_dec)
				count_q <= count_q - CNT_W'(1);
		end
	end

	assign stat.count     = count_q;
	assign stat.cur_free  = cur_free_q;
	assign stat.nxt_free  = nxt_free_q;
	assign stat.fits      = cur_cap_q >= req_q;
	assign stat.can_split = (count_q < CNT_W'(MAX_BLOCKS)) &&
	                        ({2'b0, cur_cap_q} >= split_need);
	assign stat.match     = ({1'b0, cur_start_q} + 17'(HEADER_BYTES)) == {1'b0, roff_q};
	assign stat.payload   = cur_start_q + OFS_W'(HEADER_BYTES);

endmodule

// ----- src/ffba_controller.sv -----
// Controller: sequences the table walk, merges, splits and table moves.
// Depends on ffba_pkg; drives ffba_datapath through dp_cmd_t.
module ffba_controller import ffba_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_type,
	input  logic [CAP_W-1:0] in_bytes,
	input  logic [OFS_W-1:0] in_roff,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      out_status,
	output logic [OFS_W-1:0] out_payload,
	output dp_cmd_t         cmd,
	input  dp_stat_t        stat
);

	typedef enum logic [11:0] {
		S_INIT = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_RD   = 12'b000000000100,
		S_CHK  = 12'b000000001000,
		S_RDN  = 12'b000000010000,
		S_MCHK = 12'b000000100000,
		S_MOVE = 12'b000001000000,
		S_MNXT = 12'b000010000000,
		S_FIT  = 12'b000100000000,
		S_WRS  = 12'b001000000000,
		S_WRB  = 12'b010000000000,
		S_OUT  = 12'b100000000000
	} state_t;

	state_t           state_q;
	logic             type_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] src_q;     // move: next source index
	logic [IDX_W-1:0] dst_q;     // move: destination of the entry in the buffer
	logic [CNT_W-1:0] left_q;    // move: entries still to read
	logic             up_q;      // move direction: up opens a slot, down closes one
	logic             prim_q;    // move buffer holds an entry
	logic [1:0]       st_q;
	logic [OFS_W-1:0] pay_q;
	logic [CNT_W-1:0] idx_n1;
	logic             has_next;

	assign idx_n1   = CNT_W'(idx_q) + CNT_W'(1);
	assign has_next = idx_n1 < stat.count;
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.idx = idx_q;
		cmd.src = src_q[IDX_W-1:0];
		cmd.req_bytes = in_bytes;
		cmd.roff = in_roff;
		case (state_q)
			S_INIT: begin
				cmd.op  = OP_INIT;
				cmd.idx = '0;
			end
			S_IDLE: cmd.load_req = in_valid && in_ready;
			S_RD:   cmd.op = OP_READ;
			S_CHK:  cmd.set_free = (type_q == REQ_RELEASE) && stat.match;
			S_RDN: begin
				cmd.op  = OP_NEXT;
				cmd.idx = idx_n1[IDX_W-1:0];
			end
			S_MCHK: cmd.absorb = stat.nxt_free;
			S_MOVE: begin
				cmd.op      = OP_MOVE;
				cmd.idx     = dst_q;
				cmd.mv_wr   = prim_q;
				// The merged-away entry leaves the table when its move is done.
				cmd.cnt_dec = !up_q && (left_q == '0);
			end
			S_FIT: cmd.clr_free = (type_q == REQ_ALLOC) && stat.cur_free && stat.fits;
			S_WRS: begin
				cmd.op      = OP_WRREM;
				cmd.idx     = idx_n1[IDX_W-1:0];
				cmd.cnt_inc = 1'b1;
			end
			S_WRB: cmd.op = OP_WRCUR;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			out_valid <= 1'b0;
			type_q    <= REQ_ALLOC;
			idx_q     <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			left_q    <= '0;
			up_q      <= 1'b0;
			prim_q    <= 1'b0;
			st_q      <= ST_OK;
			pay_q     <= '0;
		end else begin
			if (state_q == S_OUT)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: if (in_valid && in_ready) begin
					type_q  <= in_type;
					idx_q   <= '0;
					pay_q   <= '0;
					st_q    <= (in_type == REQ_ALLOC) ? ST_NO_SPACE : ST_BAD_FREE;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (type_q == REQ_RELEASE) begin
						if (stat.match) begin
							st_q    <= ST_OK;
							state_q <= has_next ? S_RDN : S_WRB;
						end else if (has_next) begin
							idx_q   <= idx_n1[IDX_W-1:0];
							state_q <= S_RD;
						end else
							state_q <= S_OUT;
					end else
						state_q <= (stat.cur_free && has_next) ? S_RDN : S_FIT;
				end
				S_RDN: state_q <= S_MCHK;
				S_MCHK: begin
					if (stat.nxt_free) begin
						// Close the gap left by the absorbed successor.
						src_q   <= idx_n1 + CNT_W'(1);
						left_q  <= stat.count - idx_n1 - CNT_W'(1);
						up_q    <= 1'b0;
						prim_q  <= 1'b0;
						state_q <= S_MOVE;
					end else
						state_q <= (type_q == REQ_RELEASE) ? S_WRB : S_FIT;
				end
				S_MOVE: begin
					if (left_q != '0) begin
						dst_q  <= up_q ? IDX_W'(src_q + CNT_W'(1)) : IDX_W'(src_q - CNT_W'(1));
						src_q  <= up_q ? src_q - CNT_W'(1) : src_q + CNT_W'(1);
						left_q <= left_q - CNT_W'(1);
						prim_q <= 1'b1;
					end else begin
						prim_q  <= 1'b0;
						state_q <= up_q ? S_WRS : S_MNXT;
					end
				end
				S_MNXT: begin
					if (has_next)
						state_q <= S_RDN;
					else
						state_q <= (type_q == REQ_RELEASE) ? S_WRB : S_FIT;
				end
				S_FIT: begin
					if (stat.cur_free && stat.fits) begin
						st_q  <= ST_OK;
						pay_q <= stat.payload;
						if (stat.can_split) begin
							// Open a slot after the current entry for the remainder.
							src_q   <= stat.count - CNT_W'(1);
							left_q  <= stat.count - idx_n1;
							up_q    <= 1'b1;
							prim_q  <= 1'b0;
							state_q <= S_MOVE;
						end else
							state_q <= S_WRB;
					end else
						state_q <= S_WRB;
				end
				S_WRS: state_q <= S_WRB;
				S_WRB: begin
					if (st_q == ST_OK)
						state_q <= S_OUT;
					else if (has_next) begin
						idx_q   <= idx_n1[IDX_W-1:0];
						state_q <= S_RD;
					end else
						state_q <= S_OUT;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_status  = st_q;
	assign out_payload = (st_q == ST_OK) ? pay_q : '0;

endmodule

// ----- src/first_fit_block_allocator_top.sv -----
// Top level of the first-fit block allocator.
// Depends on ffba_pkg, ffba_controller and ffba_datapath.
//
// Usage: requests arrive on the s_axis channel. tuser carries req_type
// (0 allocate, 1 release); tdata carries req_bytes in bits 16:0 and
// release_offset in bits 32:17, padded to 40 bits. Each request gives
// exactly one result on m_axis: tdata bits 1:0 status, bits 17:2 the
// payload offset, padded to 24 bits.
// A request walks the table from entry 0, so the time it takes grows with
// the number of blocks passed, the successors of free blocks looked at and
// the table entries moved by a merge or a split.
// One request is in work at a time; s_axis_tready is low while it is, and
// the next request can be taken the cycle after the result is delivered.
// After reset an init pass writes the single free block that covers the
// heap; s_axis_tready rises when it is done.
// A result is held in its output register while m_axis_tready is low, and
// no new request is taken until it has been delivered.
module first_fit_block_allocator_top import ffba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // req_bytes[16:0], release_offset[32:17]
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[1:0], payload_offset[17:2]
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [1:0]       status;
	logic [OFS_W-1:0] payload;

	ffba_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_type(s_axis_tuser),
		.in_bytes(s_axis_tdata[16:0]), .in_roff(s_axis_tdata[32:17]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_status(status), .out_payload(payload),
		.cmd(cmd), .stat(stat)
	);

	ffba_datapath u_dp (.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat));

	assign m_axis_tdata = {6'b0, payload, status};

	// No request is accepted while a result waits.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	// A failed request reports no offset.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[17:2] == '0)
		else $error("nonzero offset on failure");
	// The table never holds more blocks than it has room for, nor none.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count != '0 && stat.count <= CNT_W'(MAX_BLOCKS)) else $error("count range");

endmodule

// ----- dv/tb_first_fit_block_allocator_top.sv -----
// Testbench for the first-fit block allocator: drives allocate and release
// requests, predicts each reply with a table model and checks every result.
// Depends on ffba_pkg and first_fit_block_allocator_top.
module tb_first_fit_block_allocator_top;
	import ffba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // req_bytes[16:0], release_offset[32:17]
	logic        s_axis_tuser = 1'b0;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // status[1:0], payload_offset[17:2]

	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;  // no idling on either side in the last part
	bit hold_rx = 1'b0;  // long hold-off of the receiver

	// Payload offsets handed out and not yet released; used to aim releases.
	logic [15:0] live_offsets[$];

	first_fit_block_allocator_top dut (.*);

	always #5 clk = ~clk;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
	endtask

	typedef struct {
		logic [1:0]  status;
		logic [15:0] offset;
	} reply_t;

	// Table model of the heap and queue of predicted replies.
	class heap_scoreboard;
		int unsigned blk_start[MAX_BLOCKS];
		int unsigned blk_cap[MAX_BLOCKS];
		bit          blk_free[MAX_BLOCKS];
		int unsigned n_blocks;
		reply_t      pending[$];

		function new();
			n_blocks = 1;
			blk_start[0] = 0;
			blk_cap[0] = HEAP_BYTES - HEADER_BYTES;
			blk_free[0] = 1'b1;
		endfunction

		function void absorb(int unsigned idx);
			blk_cap[idx] += HEADER_BYTES + blk_cap[idx+1];
			for (int unsigned k = idx + 1; k + 1 < n_blocks; k++) begin
				blk_start[k] = blk_start[k+1];
				blk_cap[k] = blk_cap[k+1];
				blk_free[k] = blk_free[k+1];
			end
			n_blocks--;
		endfunction

		function void coalesce(int unsigned idx);
			if (!blk_free[idx])
				return;
			while (idx + 1 < n_blocks && blk_free[idx+1])
				absorb(idx);
		endfunction

		function void carve(int unsigned idx, int unsigned q);
			for (int unsigned k = n_blocks; k > idx + 1; k--) begin
				blk_start[k] = blk_start[k-1];
				blk_cap[k] = blk_cap[k-1];
				blk_free[k] = blk_free[k-1];
			end
			blk_start[idx+1] = blk_start[idx] + HEADER_BYTES + q;
			blk_cap[idx+1] = blk_cap[idx] - q - HEADER_BYTES;
			blk_free[idx+1] = 1'b1;
			blk_cap[idx] = q;
			n_blocks++;
		endfunction

		function void note_request(logic kind, logic [16:0] bytes, logic [15:0] roff);
			reply_t r;
			int unsigned q;
			r.offset = '0;
			if (kind == REQ_ALLOC) begin
				r.status = ST_NO_SPACE;
				for (int unsigned i = 0; i < n_blocks; i++) begin
					coalesce(i);
					if (blk_free[i] && blk_cap[i] >= bytes) begin
						q = (bytes < MIN_CAPACITY) ? MIN_CAPACITY : bytes;
						if (n_blocks < MAX_BLOCKS && q + HEADER_BYTES + MIN_CAPACITY <= blk_cap[i])
							carve(i, q);
						blk_free[i] = 1'b0;
						r.status = ST_OK;
						r.offset = 16'(blk_start[i] + HEADER_BYTES);
						break;
					end
				end
			end else begin
				r.status = ST_BAD_FREE;
				for (int unsigned i = 0; i < n_blocks; i++) begin
					if (blk_start[i] + HEADER_BYTES == roff) begin
						blk_free[i] = 1'b1;
						coalesce(i);
						r.status = ST_OK;
						break;
					end
				end
			end
			pending.push_back(r);
		endfunction

		task check_reply(logic [23:0] data);
			reply_t w;
			if (pending.size() == 0) begin
				report("unexpected reply", 32'(data), 32'd0);
				return;
			end
			w = pending.pop_front();
			if (data[1:0] !== w.status)
				report("status", 32'(data[1:0]), 32'(w.status));
			if (data[17:2] !== w.offset)
				report("payload_offset", 32'(data[17:2]), 32'(w.offset));
			if (data[17:2] === w.offset && data[1:0] === ST_OK && w.offset != 0)
				live_offsets.push_back(w.offset);
		endtask
	endclass

	heap_scoreboard heap_sb = new();

	always @(posedge clk) begin
		cycles++;
		if (cycles > 30000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: checks each accepted reply and idles at random.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				heap_sb.check_reply(m_axis_tdata);
			if (hold_rx)
				m_axis_tready <= 1'b0;
			else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				gap = $urandom_range(1, 19);
				repeat (gap) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// Offers one request and waits until it is accepted.
	task automatic send_request(logic kind, logic [16:0] bytes, logic [15:0] roff);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {7'd0, roff, bytes};
		do
			@(posedge clk);
		while (!s_axis_tready);
		heap_sb.note_request(kind, bytes, roff);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected result has come.
	task automatic drain();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
		while (heap_sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// One random request: mostly allocations of modest size and releases of live blocks.
	task automatic random_request();
		int pick;
		int idx;
		logic [15:0] roff;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			send_request(REQ_ALLOC, 17'($urandom_range(0, (pick < 5) ? 65536 : 2000)), 16'($urandom));
		end else if (pick < 90 && live_offsets.size() != 0) begin
			idx = $urandom_range(0, live_offsets.size() - 1);
			roff = live_offsets[idx];
			live_offsets.delete(idx);
			send_request(REQ_RELEASE, 17'($urandom), roff);
		end else
			send_request(REQ_RELEASE, 17'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: size extremes, splits, a bad release, double release.
		send_request(REQ_ALLOC, 17'd0, 16'hFFFF);
		send_request(REQ_ALLOC, 17'd24, 16'h0000);
		send_request(REQ_ALLOC, 17'd100, 16'h0);
		send_request(REQ_ALLOC, 17'd65536, 16'h0);
		send_request(REQ_ALLOC, 17'h1FFFF, 16'h0);
		send_request(REQ_RELEASE, 17'h1FFFF, 16'd17);
		send_request(REQ_RELEASE, 17'd0, 16'd17);
		send_request(REQ_RELEASE, 17'd0, 16'd0);
		send_request(REQ_RELEASE, 17'd0, 16'hFFFF);
		send_request(REQ_RELEASE, 17'd0, 16'd20);
		send_request(REQ_ALLOC, 17'd10, 16'h0);
		send_request(REQ_ALLOC, 17'd65000, 16'h0);
		drain();
		live_offsets.delete();
		send_request(REQ_RELEASE, 17'd0, 16'd58);
		send_request(REQ_RELEASE, 17'd0, 16'd99);
		send_request(REQ_RELEASE, 17'd0, 16'd116);
		// Asks for the capacity of the whole heap while blocks are still taken, so no block fits.
		send_request(REQ_ALLOC, 17'd65519, 16'h0);
		drain();

		// Fill the table to its limit with small blocks so the no-split case is hit.
		repeat (70) send_request(REQ_ALLOC, 17'($urandom_range(0, 40)), 16'h0);
		drain();

		// Long receiver hold-off while requests keep coming.
		hold_rx = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end
			repeat (20) random_request();
		join
		drain();

		repeat (1000) random_request();
		drain();
		quiet = 1'b1;
		repeat (200) random_request();
		drain();
		repeat (500) @(posedge clk);
		if (errors == 0 && heap_sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
